FILE: hw/rtl/sim_clock_timer_device_assert.svh
// Assertion macros for the checker file of the clock timer block.
`ifndef SIM_CLOCK_TIMER_DEVICE_ASSERT_SVH
`define SIM_CLOCK_TIMER_DEVICE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SCTD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SCTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/sctd_pkg.sv
package sctd_pkg;

    // Field and register widths
    localparam int NPT_W  = 30;
    localparam int THR_W  = 32;
    localparam int DATA_W = 32;
    localparam int ADDR_W = 3;
    localparam int QUOT_W = 21;   // ns_per_tick / 1000 fits in 21 bits
    localparam int REM_W  = 10;   // remainder below 1000

    localparam int unsigned NS_PER_US  = 1000;
    localparam int unsigned US_PER_SEC = 1000000;

    // Scaled reciprocal of 1000: (x * NPT_RECIP) >> RECIP_SH is x / 1000 for any 30-bit x
    localparam int RECIP_W  = 31;
    localparam int RECIP_SH = 40;
    localparam logic [RECIP_W-1:0] NPT_RECIP = 31'd1099511628;

    // Reset values of the configuration registers
    localparam logic [NPT_W-1:0]  NPT_RESET      = 30'd1000;
    localparam logic [THR_W-1:0]  THR_RESET      = 32'd10000000;
    localparam logic [QUOT_W-1:0] NPT_QUOT_RESET = 21'd1;
    localparam logic [REM_W-1:0]  NPT_REM_RESET  = 10'd0;

    // Request operations
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Access sizes; the unused code behaves as a word
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;
    localparam logic [1:0] SIZE_WIDE = 2'd3;

    // Word slots in the device window
    localparam logic [2:0] SLOT_SEC  = 3'd0;
    localparam logic [2:0] SLOT_USEC = 3'd1;
    localparam logic [2:0] SLOT_CTRL = 3'd4;

    // Configuration register index (paddr bit 2)
    localparam logic REG_NS_PER_TICK = 1'b0;
    localparam logic REG_THRESHOLD   = 1'b1;

    localparam int CTRL_ENABLE_BIT = 0;

    // ns_per_tick split into whole microseconds and leftover nanoseconds
    typedef struct packed {
        logic [QUOT_W-1:0] quot;
        logic [REM_W-1:0]  rem;
    } npt_split_t;

endpackage

FILE: hw/rtl/sim_clock_timer_device.sv
// Simulated-time clock peripheral.
// Requests enter on in_valid/in_ready: a tick advances simulated time by
// ns_per_tick nanoseconds, a bus read returns seconds, microseconds or
// control (byte/halfword lanes little-endian), a bus write sets control.
// Every request yields one result on out_valid/out_ready: read_data and
// the interrupt level irq_line after the request.
// The result is registered at the accepting edge and, if the output register
// is free, shown on the next cycle. One request per cycle is taken while no
// split runs and out_ready is high; the timer state updates on acceptance.
// A stalled receiver holds the result in the output register; one more
// request lands in a skid register, then in_ready drops until it drains.
// The APB port holds ns_per_tick (0x0) and interrupt_threshold_ns (0x4).
// Writing ns_per_tick starts a split by 1000 (reciprocal multiply, then the
// remainder); in_ready stays low until the split is done.
// Reset clears time, control and the interrupt, empties the output side and
// loads ns_per_tick = 1000 and interrupt_threshold_ns = 10000000.
module sim_clock_timer_device (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sctd_pkg::ADDR_W-1:0]   paddr,
    input  logic [sctd_pkg::DATA_W-1:0]   pwdata,
    output logic [sctd_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    operation,
    input  logic [4:0]                    offset,
    input  logic [1:0]                    access_size,
    input  logic [31:0]                   write_data,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [31:0]                   read_data,
    output logic                          irq_line
);
    import sctd_pkg::*;

    localparam int Q_W = 23;   // stored microsecond part of the accumulator

    logic [NPT_W-1:0] npt_reg;
    logic [THR_W-1:0] thr_reg;
    logic [31:0]      acc_reg, acc_next;
    logic [Q_W-1:0]   acc_q_reg, acc_q_next;
    logic [REM_W-1:0] acc_r_reg, acc_r_next;
    logic [31:0]      usec_reg, usec_next;
    logic [31:0]      sec_reg, sec_next;
    logic [31:0]      ctrl_reg, ctrl_next;
    logic             irq_reg, irq_next;

    logic             out_valid_reg;
    logic [31:0]      out_data_reg;
    logic             out_irq_reg;
    logic             skid_valid_reg;
    logic [31:0]      skid_data_reg;
    logic             skid_irq_reg;

    logic             cfg_wr;
    logic             div_busy;
    npt_split_t       npt_split;
    logic             accept;
    logic             out_take;

    logic [32:0]      sum;
    logic             fire;
    logic [REM_W:0]   r_sum;
    logic             r_carry;
    logic [REM_W-1:0] r_new;
    logic [Q_W:0]     q_new;
    logic [31:0]      usec_add;
    logic [31:0]      usec_tick;
    logic [2:0]       slot;
    logic [31:0]      slot_word;
    logic [31:0]      lane_word;
    logic [31:0]      byte_sh;
    logic [31:0]      new_data;

    // Configuration port
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_THRESHOLD) ? thr_reg : DATA_W'(npt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            npt_reg <= NPT_RESET;
            thr_reg <= THR_RESET;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_NS_PER_TICK)
                npt_reg <= pwdata[NPT_W-1:0];
            else
                thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // ns_per_tick split into microseconds and nanoseconds
    sctd_npt_div u_npt_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cfg_wr && (paddr[2] == REG_NS_PER_TICK)),
        .dividend (pwdata[NPT_W-1:0]),
        .busy     (div_busy),
        .split    (npt_split)
    );

    // Handshake
    assign in_ready = !skid_valid_reg && !div_busy;
    assign accept   = in_valid && in_ready;
    assign out_take = out_valid_reg && out_ready;

    // Tick arithmetic; the accumulator is kept both whole and as usec:ns
    always_comb
    begin
        sum     = {1'b0, acc_reg} + 33'(npt_reg);
        fire    = sum > {1'b0, thr_reg};
        r_sum   = {1'b0, acc_r_reg} + {1'b0, npt_split.rem};
        r_carry = r_sum >= (REM_W+1)'(NS_PER_US);
        r_new   = r_carry ? REM_W'(r_sum - (REM_W+1)'(NS_PER_US)) : r_sum[REM_W-1:0];
        q_new   = {1'b0, acc_q_reg} + (Q_W+1)'(npt_split.quot) + (Q_W+1)'(r_carry);
        usec_add = usec_reg + 32'(q_new);
        if (fire)
            usec_tick = usec_add;
        else
            usec_tick = usec_reg;
    end

    // Bus slot and lane data
    always_comb
    begin
        slot = offset[4:2];
        unique case (slot)
            SLOT_SEC:  slot_word = sec_reg;
            SLOT_USEC: slot_word = usec_reg;
            SLOT_CTRL: slot_word = ctrl_reg;
            default:   slot_word = '0;
        endcase
        byte_sh = slot_word >> {offset[1:0], 3'b000};
        case (access_size)
            SIZE_BYTE: lane_word = 32'(write_data[7:0]) << {offset[1:0], 3'b000};
            SIZE_HALF: lane_word = offset[1] ? {write_data[15:0], 16'h0000}
                                             : {16'h0000, write_data[15:0]};
            default:   lane_word = write_data;
        endcase
    end

    // Next state and result of one request
    always_comb
    begin
        acc_next   = acc_reg;
        acc_q_next = acc_q_reg;
        acc_r_next = acc_r_reg;
        usec_next  = usec_reg;
        sec_next   = sec_reg;
        ctrl_next  = ctrl_reg;
        irq_next   = irq_reg;
        new_data   = '0;
        case (operation)
            OP_TICK:
            begin
                if (fire)
                begin
                    acc_next   = 32'(r_new);
                    acc_q_next = '0;
                end
                else
                begin
                    acc_next   = sum[31:0];
                    acc_q_next = q_new[Q_W-1:0];
                end
                acc_r_next = r_new;
                if (usec_tick > 32'(US_PER_SEC))
                begin
                    usec_next = usec_tick - 32'(US_PER_SEC);
                    sec_next  = sec_reg + 32'd1;
                end
                else
                begin
                    usec_next = usec_tick;
                end
                if (ctrl_reg[CTRL_ENABLE_BIT])
                    irq_next = !irq_reg && fire;
                else
                    irq_next = 1'b0;
            end
            OP_READ:
            begin
                case (access_size)
                    SIZE_BYTE: new_data = {24'h0, byte_sh[7:0]};
                    SIZE_HALF: new_data = offset[1] ? {16'h0, slot_word[31:16]}
                                                    : {16'h0, slot_word[15:0]};
                    default:   new_data = slot_word;
                endcase
            end
            OP_WRITE:
            begin
                if (slot == SLOT_CTRL)
                begin
                    ctrl_next = lane_word;
                    case (access_size) inside
                        SIZE_WORD, SIZE_WIDE: new_data = lane_word;
                        default:              new_data = '0;
                    endcase
                end
            end
            default:
            begin
                new_data = '0;
            end
        endcase
    end

    // Timer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            acc_q_reg <= '0;
            acc_r_reg <= '0;
            usec_reg  <= '0;
            sec_reg   <= '0;
            ctrl_reg  <= '0;
            irq_reg   <= 1'b0;
        end
        else if (accept)
        begin
            acc_reg   <= acc_next;
            acc_q_reg <= acc_q_next;
            acc_r_reg <= acc_r_next;
            usec_reg  <= usec_next;
            sec_reg   <= sec_next;
            ctrl_reg  <= ctrl_next;
            irq_reg   <= irq_next;
        end
    end

    // Output register and skid stage, control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_take || !out_valid_reg)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Output register and skid stage, payload
    always_ff @(posedge clk)
    begin
        if (out_take || !out_valid_reg)
        begin
            if (skid_valid_reg)
            begin
                out_data_reg <= skid_data_reg;
                out_irq_reg  <= skid_irq_reg;
            end
            else if (accept)
            begin
                out_data_reg <= new_data;
                out_irq_reg  <= irq_next;
            end
        end
        else if (accept)
        begin
            skid_data_reg <= new_data;
            skid_irq_reg  <= irq_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = out_data_reg;
    assign irq_line  = out_irq_reg;

endmodule

FILE: hw/rtl/sctd_npt_div.sv
module sctd_npt_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sctd_pkg::NPT_W-1:0]  dividend,
    output logic                        busy,
    output sctd_pkg::npt_split_t        split
);
    import sctd_pkg::*;

    localparam int PROD_W = NPT_W + RECIP_W;

    logic              mul_reg, mul_next;
    logic              fin_reg, fin_next;
    logic [NPT_W-1:0]  dvd_reg, dvd_next;
    logic [QUOT_W-1:0] quot_reg, quot_next;
    npt_split_t        split_reg, split_next;
    logic [PROD_W-1:0] prod;
    logic [NPT_W-1:0]  back;

    // Two steps: quotient by reciprocal multiply, then remainder from it
    always_comb
    begin
        prod       = PROD_W'(dvd_reg) * PROD_W'(NPT_RECIP);
        back       = NPT_W'(quot_reg) * NPT_W'(NS_PER_US);
        mul_next   = 1'b0;
        fin_next   = mul_reg;
        dvd_next   = dvd_reg;
        quot_next  = quot_reg;
        split_next = split_reg;
        if (start)
        begin
            mul_next = 1'b1;
            fin_next = 1'b0;
            dvd_next = dividend;
        end
        if (mul_reg)
            quot_next = prod[RECIP_SH +: QUOT_W];
        if (fin_reg)
        begin
            split_next.quot = quot_reg;
            split_next.rem  = REM_W'(dvd_reg - back);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_reg        <= 1'b0;
            fin_reg        <= 1'b0;
            split_reg.quot <= NPT_QUOT_RESET;
            split_reg.rem  <= NPT_REM_RESET;
        end
        else
        begin
            mul_reg   <= mul_next;
            fin_reg   <= fin_next;
            split_reg <= split_next;
        end
    end

    // Datapath, no reset
    always_ff @(posedge clk)
    begin
        dvd_reg  <= dvd_next;
        quot_reg <= quot_next;
    end

    assign busy  = mul_reg || fin_reg;
    assign split = split_reg;

endmodule

FILE: hw/rtl/sctd_checker.sv
`include "sim_clock_timer_device_assert.svh"

module sctd_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sctd_pkg::ADDR_W-1:0]   paddr,
    input  logic [sctd_pkg::DATA_W-1:0]   pwdata,
    input  logic [sctd_pkg::DATA_W-1:0]   prdata,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [31:0]                   read_data,
    input  logic                          irq_line
);
    import sctd_pkg::*;

    // A stalled result holds
    `SCTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(read_data) && $stable(irq_line), "stalled result changed")

    // Every new result comes from an accepted request
    `SCTD_ASSERT_SAME(a_out_source, $rose(out_valid), $past(in_valid && in_ready), "result without a request")

    // A new step size blocks requests while it is split
    `SCTD_ASSERT_NEXT(a_npt_stall, psel && penable && pwrite && (paddr[2] == REG_NS_PER_TICK), !in_ready, "request taken during step split")

    // Threshold reads back what was written
    `SCTD_ASSERT_SAME(a_thr_readback, (psel && penable && pwrite && (paddr[2] == REG_THRESHOLD)) ##1 ((paddr[2] == REG_THRESHOLD) && !pwrite), prdata == $past(pwdata), "threshold readback mismatch")

endmodule

bind sim_clock_timer_device sctd_checker u_sctd_checker (.*);
